// ===== sv/hpt_pkg.sv =====
package hpt_pkg;

  localparam int Q_W    = 32;
  localparam int PROD_W = 2 * Q_W;
  localparam int ACC_W  = 50;
  localparam int MAG_W  = ACC_W - 1;
  localparam int FRAC_W = 16;
  localparam int DIV_N  = 32;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W  = 64;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  localparam logic OP_POINT     = 1'b0;
  localparam logic OP_DIRECTION = 1'b1;

  typedef struct packed {
    logic                div;
    logic                clamp_sat;
    logic [2:0]          neg;
    logic [2:0]          early;
    logic [3*Q_W-1:0]    clamped;
  } side_t;

endpackage

// ===== sv/hpt_div_lane.sv =====
module hpt_div_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [hpt_pkg::MAG_W-1:0] rem_in,
  input  logic [hpt_pkg::MAG_W-1:0] den_in,
  input  logic [hpt_pkg::DIV_N-1:0] low_in,
  output logic [hpt_pkg::DIV_N-1:0] quot
);
  import hpt_pkg::*;

  logic [MAG_W-1:0] rem_q [DIV_N];
  logic [MAG_W-1:0] den_q [DIV_N];
  logic [DIV_N-1:0] sh_q  [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_step
    logic [MAG_W-1:0] rem_prev;
    logic [MAG_W-1:0] den_prev;
    logic [DIV_N-1:0] sh_prev;
    logic [MAG_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_prev = rem_in;
      assign den_prev = den_in;
      assign sh_prev  = low_in;
    end else begin : g_rest
      assign rem_prev = rem_q[i-1];
      assign den_prev = den_q[i-1];
      assign sh_prev  = sh_q[i-1];
    end

    assign trial = {rem_prev, sh_prev[DIV_N-1]};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? MAG_W'(trial - {1'b0, den_prev}) : MAG_W'(trial);
        den_q[i] <= den_prev;
        sh_q[i]  <= {sh_prev[DIV_N-2:0], ge};
      end
    end
  end

  assign quot = sh_q[DIV_N-1];

endmodule

// ===== sv/homogeneous_point_transform.sv =====
// Homogeneous 4x4 transform of Q16.16 vectors. Opcode 0 maps a point (translation added,
// divide by w when w is nonzero), opcode 1 a direction through the upper 3x3 part only.
// The matrix sits in eight 64-bit registers, written through the cfg port; the user must
// write it only while the block is idle, which is not enforced; reset loads the identity. One
// vector is accepted per cycle, and each result passes four stages of load, multiply,
// accumulate and pre-divide, a 32-stage bit-per-stage restoring divider with three lanes, and the
// output register. The pipeline holds as a whole whenever a finished result is not taken.
module homogeneous_point_transform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic                          divided,
  output logic                          saturated
);
  import hpt_pkg::*;

  logic [CFG_W-1:0] regs [NUM_REGS];
  logic signed [Q_W-1:0] ent [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'h0001_0000_0000_0000;
      regs[1] <= '0;
      regs[2] <= 64'h0000_0000_0001_0000;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= 64'h0001_0000_0000_0000;
      regs[6] <= '0;
      regs[7] <= 64'h0000_0000_0001_0000;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = (c % 2 == 1) ? regs[r*2 + c/2][31:0] : regs[r*2 + c/2][63:32];
      end
    end
  end

  logic en;
  logic v0, v1, v2, v3;
  logic [DIV_N-1:0] dv;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                  op0;
  logic signed [Q_W-1:0] vec0 [3];
  logic                  op1;
  logic signed [PROD_W-1:0] prod [4][3];
  logic                  op2;
  logic signed [ACC_W-1:0] acc [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0     <= opcode;
      vec0[0] <= in_x;
      vec0[1] <= in_y;
      vec0[2] <= in_z;
      op1     <= op0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(ent[r][c]) * PROD_W'(vec0[c]);
        end
      end
      op2 <= op1;
      for (int r = 0; r < 4; r++) begin
        acc[r] <= ACC_W'(prod[r][0] >>> FRAC_W) + ACC_W'(prod[r][1] >>> FRAC_W)
                + ACC_W'(prod[r][2] >>> FRAC_W)
                + ((op1 == OP_POINT) ? ACC_W'(ent[r][3]) : ACC_W'(0));
      end
    end
  end

  logic                  dodiv;
  logic [ACC_W-1:0]      wabs;
  logic [MAG_W-1:0]      den;
  logic [ACC_W-1:0]      nabs [3];
  logic [MAG_W-1:0]      num  [3];
  logic [Q_W-1:0]        clampv [3];
  logic [2:0]            csat, negv, earlyv;

  assign dodiv = (op2 == OP_POINT) && (acc[3] != '0);
  assign wabs  = acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
  assign den   = wabs[MAG_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nabs[k]   = acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : ACC_W'(acc[k]);
      num[k]    = nabs[k][MAG_W-1:0];
      negv[k]   = acc[k][ACC_W-1] ^ acc[3][ACC_W-1];
      earlyv[k] = {FRAC_W'(0), num[k]} >= {den, FRAC_W'(0)};
      if (acc[k] > ACC_W'(signed'(Q_MAX))) begin
        clampv[k] = Q_MAX;
        csat[k]   = 1'b1;
      end else if (acc[k] < -ACC_W'(signed'({1'b0, Q_MIN}))) begin
        clampv[k] = Q_MIN;
        csat[k]   = 1'b1;
      end else begin
        clampv[k] = acc[k][Q_W-1:0];
        csat[k]   = 1'b0;
      end
    end
  end

  side_t            side3;
  logic [MAG_W-1:0] rem3 [3];
  logic [MAG_W-1:0] den3;
  logic [DIV_N-1:0] low3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      side3.div       <= dodiv;
      side3.clamp_sat <= |csat;
      side3.neg       <= negv;
      side3.early     <= earlyv;
      side3.clamped   <= {clampv[2], clampv[1], clampv[0]};
      den3            <= den;
      for (int k = 0; k < 3; k++) begin
        rem3[k] <= MAG_W'(num[k][MAG_W-1:FRAC_W]);
        low3[k] <= {num[k][FRAC_W-1:0], FRAC_W'(0)};
      end
    end
  end

  logic [DIV_N-1:0] quot [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    hpt_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .rem_in (rem3[k]),
      .den_in (den3),
      .low_in (low3[k]),
      .quot   (quot[k])
    );
  end

  side_t side_q [DIV_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[DIV_N-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side3;
      for (int i = 1; i < DIV_N; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  side_t          sf;
  logic [Q_W-1:0] res [3];
  logic [2:0]     qsat;

  assign sf = side_q[DIV_N-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!sf.div) begin
        res[k]  = sf.clamped[k*Q_W +: Q_W];
        qsat[k] = 1'b0;
      end else if (sf.early[k]) begin
        res[k]  = sf.neg[k] ? Q_MIN : Q_MAX;
        qsat[k] = 1'b1;
      end else if (sf.neg[k]) begin
        qsat[k] = quot[k] > Q_MIN;
        res[k]  = qsat[k] ? Q_MIN : Q_W'(-quot[k]);
      end else begin
        qsat[k] = quot[k][Q_W-1];
        res[k]  = qsat[k] ? Q_MAX : quot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x     <= res[0];
      out_y     <= res[1];
      out_z     <= res[2];
      divided   <= sf.div;
      saturated <= sf.div ? |qsat : sf.clamp_sat;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && dv == '0)
    else $error("pipeline not empty after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v0)
    else $error("accepted transaction missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv) && $stable(v3))
    else $error("pipeline advanced during stall");

endmodule
